### src/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, codes and helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int MODE_W     = 3;
   localparam int DATA_W     = 32;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // request mode codes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WALK_FWD   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_WALK_BWD   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_LENGTH     = 3'd6;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_WALK   = 2'd2,
      OP_LENGTH = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_POP  = 2'd1,
      ST_WALK = 2'd2
   } back_state_type;

   // at_front: push/pop at the front, or walk front to back
   typedef struct packed {
      op_type                    op;
      logic                      at_front;
      logic signed [DATA_W-1:0]  value;
   } cmd_type;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
      if (i == IDX_W'(DEPTH - 1)) return '0;
      else return i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
      if (i == '0) return IDX_W'(DEPTH - 1);
      else return i - 1'b1;
   endfunction

endpackage

### src/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/dq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_front
// Request intake: decodes the mode into an operation and end select.
// ----------------------------------------------------------------------------
module dq_front (
   input  logic                         start,
   input  logic                         busy,
   input  logic [dq_pkg::MODE_W-1:0]    req_mode,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   output logic                         cmd_push,
   output dq_pkg::cmd_type              cmd
);
   import dq_pkg::*;

   logic known;

   always_comb begin
      known        = 1'b1;
      cmd.op       = OP_LENGTH;
      cmd.at_front = 1'b1;
      cmd.value    = req_value;
      unique case (req_mode)
         MODE_PUSH_FRONT: cmd.op = OP_PUSH;
         MODE_PUSH_BACK:  begin cmd.op = OP_PUSH; cmd.at_front = 1'b0; end
         MODE_POP_FRONT:  cmd.op = OP_POP;
         MODE_POP_BACK:   begin cmd.op = OP_POP;  cmd.at_front = 1'b0; end
         MODE_WALK_FWD:   cmd.op = OP_WALK;
         MODE_WALK_BWD:   begin cmd.op = OP_WALK; cmd.at_front = 1'b0; end
         MODE_LENGTH:     cmd.op = OP_LENGTH;
         default:         known = 1'b0;   // unused code: taken and dropped
      endcase
   end

   assign cmd_push = start && !busy && known;

endmodule

### src/dq_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cmd_fifo
// Short command queue between intake and execution.
// ----------------------------------------------------------------------------
module dq_cmd_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  dq_pkg::cmd_type push_cmd,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output dq_pkg::cmd_type head
);
   import dq_pkg::*;

   cmd_type              slots_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full      = (fill_ff == FIFO_CW'(FIFO_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/dq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_back
// Execution: owns the ring pointers and storage, produces response words.
// ----------------------------------------------------------------------------
module dq_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  dq_pkg::cmd_type                   cmd,
   output logic                              cmd_take,
   output logic                              rsp_valid,
   output logic signed [dq_pkg::DATA_W-1:0]  rsp_data,
   output logic [dq_pkg::COUNT_W-1:0]        rsp_count,
   output logic [dq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                              rsp_last
);
   import dq_pkg::*;

   back_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     front_ff, front_in;
   logic [IDX_W-1:0]     back_ff, back_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic                 forward_ff, forward_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0]    rd_data;
   logic                 is_empty, is_full, walk_done;

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign walk_done = (remain_ff == CNT_W'(1));

   dq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.op == OP_POP && !is_empty) state_in = ST_POP;
            else if (cmd_valid && cmd.op == OP_WALK && !is_empty) state_in = ST_WALK;
         end
         ST_POP:  state_in = ST_IDLE;
         ST_WALK: if (walk_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [IDX_W-1:0] first;
      first         = '0;
      cmd_take      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = back_ff;
      rd_en         = 1'b0;
      rd_addr       = walk_idx_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      walk_idx_in   = walk_idx_ff;
      remain_in     = remain_ff;
      forward_in    = forward_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = '0;
      rsp_count_in  = count_ff;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               unique case (cmd.op)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en = 1'b1;
                        if (cmd.at_front) begin
                           front_in = wrap_dec(front_ff);
                           wr_addr  = wrap_dec(front_ff);
                        end else begin
                           wr_addr = back_ff;
                           back_in = wrap_inc(back_ff);
                        end
                        count_in     = count_ff + 1'b1;
                        rsp_count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en = 1'b1;
                        if (cmd.at_front) begin
                           rd_addr  = front_ff;
                           front_in = wrap_inc(front_ff);
                        end else begin
                           rd_addr = wrap_dec(back_ff);
                           back_in = wrap_dec(back_ff);
                        end
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_WALK: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        first       = cmd.at_front ? front_ff : wrap_dec(back_ff);
                        rd_en       = 1'b1;
                        rd_addr     = first;
                        walk_idx_in = cmd.at_front ? wrap_inc(first) : wrap_dec(first);
                        remain_in   = count_ff;
                        forward_in  = cmd.at_front;
                     end
                  end
                  OP_LENGTH: rsp_valid_in = 1'b1;
                  default:   rsp_valid_in = 1'b0;
               endcase
            end
         end
         ST_POP: begin
            // count already reflects the removal
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data;
         end
         ST_WALK: begin
            // read of the next slot overlaps emission of the current word
            rd_en        = 1'b1;
            rd_addr      = walk_idx_ff;
            walk_idx_in  = forward_ff ? wrap_inc(walk_idx_ff) : wrap_dec(walk_idx_ff);
            remain_in    = remain_ff - 1'b1;
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data;
            rsp_last_in  = walk_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff   <= walk_idx_in;
      remain_ff     <= remain_in;
      forward_ff    <= forward_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = COUNT_W'(rsp_count_ff);
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

### src/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words kept in a ring of DEPTH slots.
// ----------------------------------------------------------------------------
// A request (req_mode, req_value) is taken on a clock edge where start is
// high and busy is low. It lands in a two-entry command queue; busy is high
// only while that queue is full. Mode seven is taken and ignored.
// Each response word is shown for one cycle with rsp_valid high; the
// receiver cannot stall, so no backpressure reaches the execution side.
// With the execution side idle, a push, length or error response is formed
// from the queued command and registered into the response word; a pop
// also passes the registered storage read before the response register. A
// walk reads its first word the same way, then gives one word per cycle for
// every stored entry, rsp_last on the final one.
// Execution takes a new command only while idle: a push, length or error
// leaves it idle, a pop holds it in ST_POP and a walk in ST_WALK to its end.
// Reset (synchronous) empties the deque and the command queue; storage
// contents are not cleared, and no response carries a slot never written.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dq_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [dq_pkg::DATA_W-1:0]  req_value,
   output logic                              rsp_valid,
   output logic signed [dq_pkg::DATA_W-1:0]  rsp_data,
   output logic [dq_pkg::COUNT_W-1:0]        rsp_count,
   output logic [dq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                              rsp_last
);
   import dq_pkg::*;

   logic    cmd_push, cmd_take, cmd_valid;
   cmd_type front_cmd, head_cmd;

   dq_front u_front (
      .start     (start),
      .busy      (busy),
      .req_mode  (req_mode),
      .req_value (req_value),
      .cmd_push  (cmd_push),
      .cmd       (front_cmd)
   );

   dq_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (front_cmd),
      .pop       (cmd_take),
      .full      (busy),
      .not_empty (cmd_valid),
      .head      (head_cmd)
   );

   dq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (head_cmd),
      .cmd_take   (cmd_take),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last && rsp_data == '0)
      else $error("error response must be a single zero-data word");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count == COUNT_W'(DEPTH))
      else $error("full response with wrong count");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_count == '0)
      else $error("empty response with nonzero count");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("response or busy right after reset");
`endif

endmodule

### tb/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the bounded deque: predicts every response word.
// ----------------------------------------------------------------------------
// A list of requests is built up front: a directed opening (empty errors,
// extreme values at both ends, both walks, length, the unused mode), then
// random phases that lean toward filling, draining or mixing the deque so
// that full and empty are both hit often. A falling-edge driver sends the
// requests in bursts with random gaps. A rising-edge process updates a
// shadow deque on every accepted request and queues the expected words,
// which the monitor compares field by field as they come out.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
   import dq_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam int RANDOM_REQUESTS = 360;

   typedef struct {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] value;
   } request_type;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      logic [COUNT_W-1:0]       count;
      status_type               status;
      logic                     last;
   } dq_word_type;

   typedef enum int { PHASE_FILL, PHASE_DRAIN, PHASE_MIX } phase_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [MODE_W-1:0]          req_mode;
   logic signed [DATA_W-1:0]   req_value;
   logic                       rsp_valid;
   logic signed [DATA_W-1:0]   rsp_data;
   logic [COUNT_W-1:0]         rsp_count;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_last;

   double_ended_queue uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   // pending requests and expected response words
   request_type pending_requests[$];
   dq_word_type expected_words[$];
   int          request_total;

   // shadow deque
   logic signed [DATA_W-1:0] shadow_slots[DEPTH];
   int unsigned              shadow_front;
   int unsigned              shadow_next_back;
   int unsigned              shadow_fill;

   int requests_taken;
   int words_checked;
   int full_rejects;
   int empty_rejects;
   int walk_words;
   int error_count;

   logic req_taken;
   int   burst_left;
   int   gap_left;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned slot_up(input int unsigned i);
      return (i + 1 == DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int unsigned slot_down(input int unsigned i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   function automatic void expect_word(input logic signed [DATA_W-1:0] data,
                                       input status_type status, input logic last);
      dq_word_type w;
      w.data   = data;
      w.count  = COUNT_W'(shadow_fill);
      w.status = status;
      w.last   = last;
      expected_words.push_back(w);
   endfunction

   // apply one accepted request to the shadow deque, queue its words
   function automatic void deque_apply(input logic [MODE_W-1:0] mode,
                                       input logic signed [DATA_W-1:0] value);
      int unsigned slot;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (shadow_fill == DEPTH) begin
               full_rejects++;
               expect_word('0, STATUS_FULL, 1'b1);
            end else begin
               if (mode == MODE_PUSH_FRONT) begin
                  shadow_front = slot_down(shadow_front);
                  shadow_slots[shadow_front] = value;
               end else begin
                  shadow_slots[shadow_next_back] = value;
                  shadow_next_back = slot_up(shadow_next_back);
               end
               shadow_fill++;
               expect_word('0, STATUS_OK, 1'b1);
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (shadow_fill == 0) begin
               empty_rejects++;
               expect_word('0, STATUS_EMPTY, 1'b1);
            end else begin
               if (mode == MODE_POP_FRONT) begin
                  slot = shadow_front;
                  shadow_front = slot_up(shadow_front);
               end else begin
                  shadow_next_back = slot_down(shadow_next_back);
                  slot = shadow_next_back;
               end
               shadow_fill--;
               expect_word(shadow_slots[slot], STATUS_OK, 1'b1);
            end
         end
         MODE_WALK_FWD, MODE_WALK_BWD: begin
            if (shadow_fill == 0) begin
               empty_rejects++;
               expect_word('0, STATUS_EMPTY, 1'b1);
            end else begin
               slot = (mode == MODE_WALK_FWD) ? shadow_front : slot_down(shadow_next_back);
               for (int k = 0; k < shadow_fill; k++) begin
                  expect_word(shadow_slots[slot], STATUS_OK, k == shadow_fill - 1);
                  slot = (mode == MODE_WALK_FWD) ? slot_up(slot) : slot_down(slot);
                  walk_words++;
               end
            end
         end
         MODE_LENGTH: expect_word('0, STATUS_OK, 1'b1);
         default: ;  // unused mode: taken, nothing happens
      endcase
   endfunction

   function automatic void add_request(input logic [MODE_W-1:0] mode,
                                       input logic signed [DATA_W-1:0] value);
      request_type r;
      r.mode  = mode;
      r.value = value;
      pending_requests.push_back(r);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh0000_0000;
         3: return 32'shFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(input phase_type phase);
      int r;
      int push_pct;
      int pop_pct;
      r        = $urandom_range(0, 99);
      push_pct = (phase == PHASE_FILL) ? 70 : (phase == PHASE_DRAIN) ? 15 : 40;
      pop_pct  = (phase == PHASE_FILL) ? 15 : (phase == PHASE_DRAIN) ? 65 : 35;
      if (r < push_pct)
         return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      if (r < push_pct + pop_pct)
         return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
      if (r < 97) begin
         case ($urandom_range(0, 2))
            0: return MODE_WALK_FWD;
            1: return MODE_WALK_BWD;
            default: return MODE_LENGTH;
         endcase
      end
      return MODE_UNUSED;
   endfunction

   task automatic build_stimulus();
      int        counted;
      int        phase_len;
      phase_type phase;
      // empty deque: every empty error path, then extremes at both ends
      add_request(MODE_LENGTH,     pick_value());
      add_request(MODE_POP_FRONT,  32'sh1234_5678);
      add_request(MODE_POP_BACK,   32'sh0);
      add_request(MODE_WALK_FWD,   32'sh0);
      add_request(MODE_WALK_BWD,   32'sh0);
      add_request(MODE_PUSH_BACK,  32'sh7FFF_FFFF);
      add_request(MODE_PUSH_FRONT, 32'sh8000_0000);
      add_request(MODE_PUSH_BACK,  32'sh0000_0000);
      add_request(MODE_PUSH_FRONT, 32'shFFFF_FFFF);
      add_request(MODE_WALK_FWD,   32'sh0);
      add_request(MODE_WALK_BWD,   32'sh0);
      add_request(MODE_LENGTH,     32'sh0);
      add_request(MODE_UNUSED,     32'sh5A5A_A5A5);
      add_request(MODE_POP_FRONT,  32'sh0);
      add_request(MODE_POP_BACK,   32'sh0);
      add_request(MODE_WALK_FWD,   32'sh0);
      add_request(MODE_POP_BACK,   32'sh0);
      add_request(MODE_POP_FRONT,  32'sh0);
      add_request(MODE_POP_FRONT,  32'sh0);
      add_request(MODE_LENGTH,     32'sh0);
      // random phases, the first one filling so full is reached early
      counted = 0;
      phase   = PHASE_FILL;
      while (counted < RANDOM_REQUESTS) begin
         phase_len = $urandom_range(20, 60);
         for (int i = 0; i < phase_len && counted < RANDOM_REQUESTS; i++) begin
            request_type r;
            r.mode  = pick_mode(phase);
            r.value = pick_value();
            pending_requests.push_back(r);
            if (r.mode != MODE_UNUSED) counted++;
         end
         case ($urandom_range(0, 2))
            0: phase = PHASE_FILL;
            1: phase = PHASE_DRAIN;
            default: phase = PHASE_MIX;
         endcase
      end
      request_total = pending_requests.size();
   endtask

   // acceptance and prediction
   always @(posedge clock) begin
      req_taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         deque_apply(req_mode, req_value);
         requests_taken++;
      end
   end

   // driver: bursts of requests with random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !req_taken) begin
            // held off by busy: keep the word on the bus
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (pending_requests.size() > 0) begin
            request_type r;
            r = pending_requests.pop_front();
            req_mode  <= r.mode;
            req_value <= r.value;
            start     <= 1'b1;
            if (--burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : response_check
      dq_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t ERROR: unexpected word: expected none, actual %0d/%0d/%0d/%0b",
                     $time, rsp_data, rsp_count, rsp_status, rsp_last);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (rsp_data !== want.data) begin
               $display("%0t ERROR: data expected %0d, actual %0d", $time, want.data, rsp_data);
               error_count++;
            end
            if (rsp_count !== want.count) begin
               $display("%0t ERROR: count expected %0d, actual %0d", $time, want.count, rsp_count);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t ERROR: status expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t ERROR: last expected %0b, actual %0b", $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      int drain_cycles;
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = MODE_LENGTH;
      req_value        = '0;
      req_taken        = 1'b0;
      burst_left       = 1;
      gap_left         = 0;
      shadow_front     = 0;
      shadow_next_back = 0;
      shadow_fill      = 0;
      requests_taken   = 0;
      words_checked    = 0;
      full_rejects     = 0;
      empty_rejects    = 0;
      walk_words       = 0;
      error_count      = 0;
      build_stimulus();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      while (requests_taken < request_total) @(negedge clock);
      drain_cycles = 0;
      while (expected_words.size() > 0 && drain_cycles < 2000) begin
         @(negedge clock);
         drain_cycles++;
      end
      // room for any stray word after the last expected one
      repeat (10) @(negedge clock);
      if (expected_words.size() > 0) begin
         $display("%0t ERROR: %0d expected words never arrived", $time, expected_words.size());
         error_count++;
      end
      $display("Ran %0d requests: %0d words checked, %0d from walks", requests_taken,
               words_checked, walk_words);
      $display("Rejected %0d pushes on a full deque and %0d requests on an empty one",
               full_rejects, empty_rejects);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### double_ended_queue.f
src/dq_pkg.sv
src/dq_ram.sv
src/dq_front.sv
src/dq_cmd_fifo.sv
src/dq_back.sv
src/double_ended_queue.sv
tb/tb_double_ended_queue.sv
